[sv/fdq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the frame descriptor queue.
// Depends on nothing; imported by the core and its checker.
package fdq_pkg;

  // Default storage shape.
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_SIZE_BITS   = 24;

  // Fixed field widths.
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 5;
  localparam int TOTAL_W = 28;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Register reset values.
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic               DROP_MODE_RESET = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_DROP_MODE = 1'b1;

  // Request opcodes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_DONE
  } fdq_state_t;

endpackage

[sv/fdq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/frame_descriptor_queue_drop_oldest_core.sv]
`timescale 1ns / 1ps
// Frame descriptor queue with drop-oldest option and byte accounting.
// An accepted request is captured in S_IDLE. A drop-mode push into a full queue first
// discards oldest entries in S_DROP, one store read per entry; the result is registered
// from S_DONE once the result slot is free. Other requests stall meanwhile.
// Reset (sync, rst high) clears pointers, counts, byte total, marks and out_valid, and
// loads config reset values; the store is not cleared (only written entries are read).
module frame_descriptor_queue_drop_oldest_core
  import fdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int SIZE_BITS   = DEFAULT_SIZE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [TAG_W-1:0]     frame_tag,
  input  logic [SIZE_BITS-1:0] frame_bytes,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [COUNT_W-1:0]   dropped_entries,
  output logic [TAG_W-1:0]     out_tag,
  output logic [SIZE_BITS-1:0] popped_bytes,
  output logic [COUNT_W-1:0]   depth_now,
  output logic [TOTAL_W-1:0]   bytes_now,
  output logic [COUNT_W-1:0]   peak_depth,
  output logic [TOTAL_W-1:0]   peak_bytes
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int DATA_W = TAG_W + SIZE_BITS;
  localparam int SUM_W  = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  // Saturating add of an entry size to the byte total.
  function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] total,
                                                 input logic [SIZE_BITS-1:0] size);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(total) + SUM_W'(size);
    add_sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  // Subtraction of an entry size from the byte total, clamped at zero.
  function automatic logic [TOTAL_W-1:0] sub_clamp(input logic [TOTAL_W-1:0] total,
                                                   input logic [SIZE_BITS-1:0] size);
    logic [SUM_W-1:0] diff;
    diff = SUM_W'(total) - SUM_W'(size);
    sub_clamp = (SUM_W'(total) >= SUM_W'(size)) ? diff[TOTAL_W-1:0] : '0;
  endfunction

  // Ring pointer advance, wrapping at the storage depth.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic [COUNT_W-1:0] capacity_limit;
  logic               drop_oldest_mode;

  // Queue state.
  fdq_state_t         state, state_next;
  logic [PTR_W-1:0]   head_ptr, head_ptr_next;
  logic [PTR_W-1:0]   tail_ptr, tail_ptr_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [TOTAL_W-1:0] byte_total, byte_total_next;
  logic [COUNT_W-1:0] depth_mark, depth_mark_next;
  logic [TOTAL_W-1:0] bytes_mark, bytes_mark_next;
  logic [COUNT_W-1:0] drop_count, drop_count_next;

  // Request held while it is worked on.
  logic               req_cmd;
  logic [TAG_W-1:0]   req_tag;
  logic [SIZE_BITS-1:0] req_bytes;

  // Store interface.
  logic               ram_wr_en, ram_rd_en;
  logic [PTR_W-1:0]   ram_rd_addr;
  logic [DATA_W-1:0]  ram_rd_data;
  logic [TAG_W-1:0]   rd_tag;
  logic [SIZE_BITS-1:0] rd_bytes;

  logic [COUNT_W-1:0] cap;
  logic               accept;
  logic               slot_free;
  logic               drop_needed;
  logic               pop_hit;
  logic               push_fits;
  logic [COUNT_W-1:0] count_dec;
  logic [COUNT_W-1:0] count_inc;
  logic [TOTAL_W-1:0] total_sub;
  logic [TOTAL_W-1:0] total_add;
  logic               result_load;

  // Effective capacity: zero acts as one, anything above storage saturates.
  always_comb begin
    if (capacity_limit == '0) begin
      cap = COUNT_W'(1);
    end else if (int'(capacity_limit) > QUEUE_DEPTH) begin
      cap = COUNT_W'(QUEUE_DEPTH);
    end else begin
      cap = capacity_limit;
    end
  end

  // Configuration port: always ready, registers written on the access phase.
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY:  prdata = CFG_DW'(capacity_limit);
      REG_DROP_MODE: prdata = CFG_DW'(drop_oldest_mode);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit   <= CAPACITY_RESET;
      drop_oldest_mode <= DROP_MODE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_CAPACITY:  capacity_limit   <= pwdata[COUNT_W-1:0];
        REG_DROP_MODE: drop_oldest_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Shared decode of the queue state.
  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign slot_free   = !out_valid || !out_stall;
  assign count_dec   = entry_count - 1'b1;
  assign count_inc   = entry_count + 1'b1;
  assign rd_tag      = ram_rd_data[DATA_W-1:SIZE_BITS];
  assign rd_bytes    = ram_rd_data[SIZE_BITS-1:0];
  assign total_sub   = sub_clamp(byte_total, rd_bytes);
  assign total_add   = add_sat(byte_total, req_bytes);
  assign drop_needed = drop_oldest_mode && (entry_count >= cap);
  assign pop_hit     = (entry_count != '0);
  assign push_fits   = (entry_count < cap);
  assign result_load = (state == S_DONE) && slot_free;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_PUSH && drop_needed) ? S_DROP : S_DONE;
        end
      end
      S_DROP: begin
        if (count_dec < cap) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Store accesses and state updates for each sequencer state.
  always_comb begin
    ram_rd_en        = 1'b0;
    ram_rd_addr      = head_ptr;
    ram_wr_en        = 1'b0;
    head_ptr_next    = head_ptr;
    tail_ptr_next    = tail_ptr;
    entry_count_next = entry_count;
    byte_total_next  = byte_total;
    depth_mark_next  = depth_mark;
    bytes_mark_next  = bytes_mark;
    drop_count_next  = drop_count;
    unique case (state)
      S_IDLE: begin
        drop_count_next = '0;
        // Fetch the oldest entry for a pop or for the first discard.
        if (accept && ((cmd == CMD_PUSH && drop_needed) || (cmd == CMD_POP && pop_hit))) begin
          ram_rd_en = 1'b1;
        end
      end
      S_DROP: begin
        // Discard the fetched oldest entry and fetch the next one if still full.
        head_ptr_next    = advance(head_ptr);
        entry_count_next = count_dec;
        byte_total_next  = total_sub;
        drop_count_next  = drop_count + 1'b1;
        if (count_dec >= cap) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = advance(head_ptr);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          if (req_cmd == CMD_PUSH) begin
            if (push_fits) begin
              ram_wr_en        = 1'b1;
              tail_ptr_next    = advance(tail_ptr);
              entry_count_next = count_inc;
              byte_total_next  = total_add;
              if (count_inc > depth_mark) begin
                depth_mark_next = count_inc;
              end
              if (total_add > bytes_mark) begin
                bytes_mark_next = total_add;
              end
            end
          end else if (pop_hit) begin
            head_ptr_next    = advance(head_ptr);
            entry_count_next = count_dec;
            byte_total_next  = total_sub;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
      byte_total  <= '0;
      depth_mark  <= '0;
      bytes_mark  <= '0;
      drop_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head_ptr    <= head_ptr_next;
      tail_ptr    <= tail_ptr_next;
      entry_count <= entry_count_next;
      byte_total  <= byte_total_next;
      depth_mark  <= depth_mark_next;
      bytes_mark  <= bytes_mark_next;
      drop_count  <= drop_count_next;
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= cmd;
      req_tag   <= frame_tag;
      req_bytes <= frame_bytes;
    end
  end

  // Result register, loaded as the request retires.
  always_ff @(posedge clk) begin
    if (result_load) begin
      depth_now  <= entry_count_next;
      bytes_now  <= byte_total_next;
      peak_depth <= depth_mark_next;
      peak_bytes <= bytes_mark_next;
      if (req_cmd == CMD_PUSH) begin
        ok              <= push_fits;
        dropped_entries <= drop_count;
        out_tag         <= '0;
        popped_bytes    <= '0;
      end else begin
        ok              <= pop_hit;
        dropped_entries <= '0;
        out_tag         <= pop_hit ? rd_tag : '0;
        popped_bytes    <= pop_hit ? rd_bytes : '0;
      end
    end
  end

  // Descriptor store: tag and size side by side in one word.
  fdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(tail_ptr),
    .wr_data({req_tag, req_bytes}),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule

[sv/fdq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the frame descriptor queue, bound to the core.
// Depends on fdq_pkg and on frame_descriptor_queue_drop_oldest_core.
module fdq_checker
  import fdq_pkg::*;
#(
  parameter int SIZE_BITS = DEFAULT_SIZE_BITS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 ok,
  input logic [COUNT_W-1:0]   dropped_entries,
  input logic [TAG_W-1:0]     out_tag,
  input logic [SIZE_BITS-1:0] popped_bytes,
  input logic [COUNT_W-1:0]   depth_now,
  input logic [TOTAL_W-1:0]   bytes_now,
  input logic [COUNT_W-1:0]   peak_depth,
  input logic [TOTAL_W-1:0]   peak_bytes
);

  // A stalled result stays and holds its depth, byte total, tag, popped size and ok fields.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(depth_now) && $stable(bytes_now)
      && $stable(out_tag) && $stable(popped_bytes) && $stable(ok))
    else $error("stalled result changed");

  // Depth and bytes only grow on pushes, which raise the marks as well.
  a_marks_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> depth_now <= peak_depth && bytes_now <= peak_bytes)
    else $error("queue level above its high-water mark");

  // Discards happen only on an accepted push, which returns no descriptor.
  a_drop_is_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_entries != '0 |-> ok && out_tag == '0 && popped_bytes == '0)
    else $error("discard reported on a pop or a refused push");

  // A failed request reports nothing.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> dropped_entries == '0 && out_tag == '0 && popped_bytes == '0)
    else $error("failed request carries data");

endmodule

bind frame_descriptor_queue_drop_oldest_core fdq_checker #(
  .SIZE_BITS(SIZE_BITS)
) u_fdq_checker (.*);

[test/frame_descriptor_queue_drop_oldest_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the frame descriptor queue core: directed corner cases,
// then random push/pop traffic under changing capacity and drop settings.
// Depends on fdq_pkg and frame_descriptor_queue_drop_oldest_core.
module frame_descriptor_queue_drop_oldest_core_test;
  import fdq_pkg::*;

  localparam int DEPTH  = DEFAULT_QUEUE_DEPTH;
  localparam int SIZE_W = DEFAULT_SIZE_BITS;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int RESULT_SLOTS = 4096;

  // One response of the queue, field for field.
  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] dropped;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  nbytes;
    logic [COUNT_W-1:0] depth;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] peak_depth;
    logic [TOTAL_W-1:0] peak_total;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = CMD_PUSH;
  logic [TAG_W-1:0]   frame_tag = '0;
  logic [SIZE_W-1:0]  frame_bytes = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [COUNT_W-1:0] dropped_entries;
  logic [TAG_W-1:0]   out_tag;
  logic [SIZE_W-1:0]  popped_bytes;
  logic [COUNT_W-1:0] depth_now;
  logic [TOTAL_W-1:0] bytes_now;
  logic [COUNT_W-1:0] peak_depth;
  logic [TOTAL_W-1:0] peak_bytes;

  frame_descriptor_queue_drop_oldest_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .frame_tag(frame_tag), .frame_bytes(frame_bytes),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .dropped_entries(dropped_entries), .out_tag(out_tag),
    .popped_bytes(popped_bytes),
    .depth_now(depth_now), .bytes_now(bytes_now),
    .peak_depth(peak_depth), .peak_bytes(peak_bytes)
  );

  // Shadow copy of the queue and its registers.
  logic [TAG_W-1:0]   q_tags [DEPTH];
  logic [SIZE_W-1:0]  q_sizes [DEPTH];
  logic [PTR_W-1:0]   q_head = '0;
  logic [PTR_W-1:0]   q_tail = '0;
  logic [COUNT_W-1:0] q_count = '0;
  logic [TOTAL_W-1:0] q_total = '0;
  logic [COUNT_W-1:0] q_peak_depth = '0;
  logic [TOTAL_W-1:0] q_peak_total = '0;
  logic [COUNT_W-1:0] cfg_capacity = CAPACITY_RESET;
  logic               cfg_drop_oldest = DROP_MODE_RESET;

  // Expected results in order, written by the sender and read by the checker.
  queue_result_t expected_results [RESULT_SLOTS];
  int expected_wr = 0;
  int expected_rd = 0;
  queue_result_t seen;
  queue_result_t want;
  int mismatch_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[frame_descriptor_queue_drop_oldest_core] ERROR");
    $finish;
  end

  // Removes the head entry, clamping the byte total at zero.
  function automatic void retire_oldest();
    q_total = (q_total >= q_sizes[q_head]) ? q_total - q_sizes[q_head] : '0;
    q_head  = q_head + 1'b1;
    q_count = q_count - 1'b1;
  endfunction

  // Applies one request to the shadow queue and returns the response it must produce.
  function automatic queue_result_t predict_queue_result(input logic op,
                                                         input logic [TAG_W-1:0] tag,
                                                         input logic [SIZE_W-1:0] nbytes);
    queue_result_t r;
    int limit;
    logic [TOTAL_W:0] sum;
    r = '0;
    limit = (cfg_capacity == 0) ? 1 : int'(cfg_capacity);
    if (limit > DEPTH) limit = DEPTH;
    if (op == CMD_PUSH) begin
      if (cfg_drop_oldest || q_count < limit) begin
        while (q_count >= limit) begin
          retire_oldest();
          r.dropped = r.dropped + 1'b1;
        end
        q_tags[q_tail]  = tag;
        q_sizes[q_tail] = nbytes;
        q_tail  = q_tail + 1'b1;
        q_count = q_count + 1'b1;
        sum = {1'b0, q_total} + nbytes;
        q_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        if (q_count > q_peak_depth) q_peak_depth = q_count;
        if (q_total > q_peak_total) q_peak_total = q_total;
        r.ok = 1'b1;
      end
    end else if (q_count > 0) begin
      r.tag    = q_tags[q_head];
      r.nbytes = q_sizes[q_head];
      retire_oldest();
      r.ok = 1'b1;
    end
    r.depth      = q_count;
    r.total      = q_total;
    r.peak_depth = q_peak_depth;
    r.peak_total = q_peak_total;
    return r;
  endfunction

  function automatic string describe(input queue_result_t r);
    return $sformatf("ok=%0d dropped=%0d tag=%h bytes=%h depth=%0d total=%h peak=%0d/%h",
                     r.ok, r.dropped, r.tag, r.nbytes, r.depth, r.total,
                     r.peak_depth, r.peak_total);
  endfunction

  // Result checker: sampled at the falling edge, accepted at the next rising edge.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{ok: ok, dropped: dropped_entries, tag: out_tag, nbytes: popped_bytes,
               depth: depth_now, total: bytes_now, peak_depth: peak_depth,
               peak_total: peak_bytes};
      if (expected_wr == expected_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result: %s", describe(seen));
      end else begin
        want = expected_results[expected_rd % RESULT_SLOTS];
        expected_rd++;
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
          end
        end
      end
    end
  end

  // Receiver stall pattern: switches at random between none, rare, frequent and toggling stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= ~out_stall;
      end
    endcase
  end

  // Sends one request in the sender's burst pattern and records its expected result.
  task automatic send_request(input logic op, input logic [TAG_W-1:0] tag,
                              input logic [SIZE_W-1:0] nbytes);
    logic taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 10);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    frame_tag   <= tag;
    frame_bytes <= nbytes;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_results[expected_wr % RESULT_SLOTS] = predict_queue_result(op, tag, nbytes);
    expected_wr++;
    burst_left--;
  endtask

  // Stops sending and waits until every outstanding request has been answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_wr != expected_rd) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic reg_sel, input logic [4:0] value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {27'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_CAPACITY) cfg_capacity = value;
    else cfg_drop_oldest = value[0];
    @(posedge clk);
  endtask

  task automatic set_queue_limits(input logic [4:0] capacity, input logic drop_oldest);
    drain_results();
    write_register(REG_CAPACITY, capacity);
    write_register(REG_DROP_MODE, {4'($urandom), drop_oldest});
  endtask

  // Field extremes and a pop on an empty queue, with reset settings.
  task automatic test_field_extremes();
    send_request(CMD_POP, 16'h1234, 24'h123456);
    send_request(CMD_PUSH, '0, '0);
    send_request(CMD_PUSH, '1, '1);
    send_request(CMD_POP, '0, '0);
    send_request(CMD_POP, '1, '1);
  endtask

  // Capacity zero behaves as a single-entry queue.
  task automatic test_capacity_zero();
    set_queue_limits(5'd0, 1'b1);
    send_request(CMD_PUSH, 16'hA5A5, 24'h5A5A5A);
    send_request(CMD_PUSH, 16'h5A5A, 24'hA5A5A5);
    send_request(CMD_POP, '0, '0);
  endtask

  // Refuse mode leaves a full queue untouched.
  task automatic test_refuse_when_full();
    set_queue_limits(5'd2, 1'b0);
    send_request(CMD_PUSH, 16'h0001, 24'd100);
    send_request(CMD_PUSH, 16'h0002, 24'd200);
    send_request(CMD_PUSH, 16'h0003, 24'd300);
    send_request(CMD_POP, '0, '0);
  endtask

  // Capacity lowered below the current depth, in refuse mode and then in drop mode.
  task automatic test_capacity_lowered();
    set_queue_limits(5'd4, 1'b0);
    send_request(CMD_PUSH, 16'h0010, 24'd1000);
    send_request(CMD_PUSH, 16'h0011, 24'd2000);
    send_request(CMD_PUSH, 16'h0012, 24'd3000);
    send_request(CMD_PUSH, 16'h0013, 24'd4000);
    set_queue_limits(5'd2, 1'b0);
    send_request(CMD_PUSH, 16'h0014, 24'd5000);
    send_request(CMD_POP, '0, '0);
    set_queue_limits(5'd1, 1'b1);
    send_request(CMD_PUSH, 16'h0015, 24'd6000);
    send_request(CMD_POP, '0, '0);
  endtask

  // Capacities above the storage size saturate.
  task automatic test_capacity_saturation();
    set_queue_limits(5'd31, 1'b1);
    send_request(CMD_PUSH, 16'h0020, 24'hFFFFFF);
    set_queue_limits(5'd17, 1'b1);
    send_request(CMD_PUSH, 16'h0021, 24'h000001);
  endtask

  // Random traffic in phases, each with its own settings and push/pop mix.
  task automatic test_random_traffic();
    int sent;
    int phase;
    int items;
    int push_pct;
    logic [4:0] capacity;
    logic drop_oldest;
    logic op;
    logic [SIZE_W-1:0] nbytes;
    logic [4:0] opening_caps[6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd16};
    sent = 0;
    phase = 0;
    while (sent < 1130) begin
      if (phase < 6) begin
        capacity = opening_caps[phase];
        drop_oldest = phase[0];
      end else begin
        capacity = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 16))
                                                : 5'($urandom_range(0, 31));
        drop_oldest = 1'($urandom_range(0, 1));
      end
      set_queue_limits(capacity, drop_oldest);
      case ($urandom_range(0, 3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 65;
        default: push_pct = 85;
      endcase
      items = $urandom_range(50, 120);
      if (items > 1130 - sent) items = 1130 - sent;
      repeat (items) begin
        op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        case ($urandom_range(0, 7))
          0: nbytes = '0;
          1: nbytes = '1;
          2, 3: nbytes = SIZE_W'($urandom_range(0, 1500));
          default: nbytes = SIZE_W'($urandom);
        endcase
        send_request(op, TAG_W'($urandom), nbytes);
        sent++;
        // Occasionally hold off until the queue has answered everything.
        if ($urandom_range(0, 79) == 0) drain_results();
      end
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_capacity_zero();
    test_refuse_when_full();
    test_capacity_lowered();
    test_capacity_saturation();
    test_random_traffic();
    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_wr == expected_rd) begin
      $display("[frame_descriptor_queue_drop_oldest_core] OK");
    end else begin
      $display("[frame_descriptor_queue_drop_oldest_core] ERROR");
    end
    $finish;
  end

endmodule

[frame_descriptor_queue_drop_oldest_core.f]
sv/fdq_pkg.sv
sv/fdq_ram.sv
sv/frame_descriptor_queue_drop_oldest_core.sv
sv/fdq_checker.sv
test/frame_descriptor_queue_drop_oldest_core_test.sv
